@@ design/zsn_pkg.sv @@
`timescale 1ns / 1ps
package zsn_pkg;

    // Fixed data widths
    localparam int SMP_W      = 16;
    localparam int FRAC_SHIFT = 22;
    localparam int ROOT_W     = 32;
    localparam int SQ_W       = 64;
    localparam int QUO_W      = 16;

    // A quotient at or above this bound saturates in either direction
    localparam logic [QUO_W:0] SAT_BOUND = 17'd32769;
    localparam logic [QUO_W-1:0] POS_MAX = 16'h7FFF;
    localparam logic [QUO_W-1:0] NEG_MIN = 16'h8000;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    last_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] value;
        logic                    passed_through;
        logic                    last_result;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MUL_NQ,
        ST_MUL_SS,
        ST_DIFF,
        ST_SQRT,
        ST_LIM,
        ST_READ,
        ST_NUM,
        ST_CHK,
        ST_DIV,
        ST_EMIT,
        ST_WAIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_nq;
        logic mul_ss;
        logic diff;
        logic sqrt_step;
        logic lim;
        logic rd;
        logic num;
        logic chk;
        logic div_step;
        logic emit;
        logic next;
        logic clr;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic closing;
        logic sqrt_done;
        logic pass;
        logic div_done;
        logic last_idx;
        logic out_taken;
    } t_status;

endpackage

@@ design/zsn_ctrl.sv @@
`timescale 1ns / 1ps
module zsn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  zsn_pkg::t_status i_status,
    output logic             o_in_stall,
    output zsn_pkg::t_cmd    o_cmd
);
    import zsn_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.closing) n_state = ST_MUL_NQ;
                end
            end
            ST_MUL_NQ: begin
                o_cmd.mul_nq = 1'b1;
                n_state = ST_MUL_SS;
            end
            ST_MUL_SS: begin
                o_cmd.mul_ss = 1'b1;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_done) n_state = ST_LIM;
            end
            ST_LIM: begin
                o_cmd.lim = 1'b1;
                n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_state = i_status.pass ? ST_EMIT : ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.out_taken) begin
                    if (i_status.last_idx) begin
                        o_cmd.clr = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

endmodule

@@ design/zsn_datapath.sv @@
`timescale 1ns / 1ps
module zsn_datapath #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zsn_pkg::t_in_word i_in_word,
    input  logic              i_out_stall,
    input  zsn_pkg::t_cmd     i_cmd,
    output zsn_pkg::t_status  o_status,
    output logic              o_out_valid,
    output zsn_pkg::t_out_word o_out_word
);
    import zsn_pkg::*;

    localparam int IW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = SMP_W + CW;          // running sum
    localparam int QW  = 2 * SMP_W + CW;      // sum of squares
    localparam int DW  = CW + QW;             // N*Q and D
    localparam int NW  = SMP_W + CW + 2;      // N*x - S
    localparam int LW  = ROOT_W + QUO_W + 1;  // saturation bound times root
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_SAMPLES - 1);

    logic signed [SMP_W-1:0] r_mem [MAX_SAMPLES];
    logic signed [SMP_W-1:0] r_rd_data;

    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_idx;
    logic signed [SW-1:0] r_sum;
    logic [QW-1:0]        r_sq;
    logic [DW-1:0]        r_nq;
    logic [DW-1:0]        r_ss;
    logic [DW-1:0]        r_d;

    logic [SQ_W-1:0] r_v, r_bit, r_res;
    logic [LW-1:0]   r_lim;

    logic                 r_neg;
    logic [NW-1:0]        r_mag;
    logic [SQ_W-1:0]      r_rem;
    logic                 r_sat;
    logic [QUO_W-1:0]     r_q;
    logic [3:0]           r_dcnt;

    logic      r_out_valid;
    t_out_word r_out_word;

    // Combinational helpers
    logic signed [2*SMP_W-1:0] sq_prod;
    logic [SW-1:0]             s_mag;
    logic [SQ_W-1:0]           sq_t;
    logic [ROOT_W-1:0]         root;
    logic signed [NW-1:0]      num;
    logic [SQ_W-1:0]           dividend;
    logic [SQ_W-1:0]           dv_t;
    logic [QUO_W-1:0]          z_val;

    assign sq_prod  = i_in_word.sample * i_in_word.sample;
    assign s_mag    = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign sq_t     = r_res + r_bit;
    assign root     = r_res[ROOT_W-1:0];
    assign num      = NW'($signed({1'b0, r_count})) * NW'(r_rd_data) - NW'(r_sum);
    assign dividend = SQ_W'(r_mag) << FRAC_SHIFT;
    assign dv_t     = SQ_W'(root) << r_dcnt;

    // Signed result from quotient and saturation
    always_comb begin
        if (r_sat) begin
            z_val = r_neg ? NEG_MIN : POS_MAX;
        end else if (r_neg) begin
            z_val = QUO_W'(-r_q);
        end else begin
            z_val = (r_q == NEG_MIN) ? POS_MAX : r_q;
        end
    end

    // Sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_mem[r_count[IW-1:0]] <= i_in_word.sample;
        if (i_cmd.rd)   r_rd_data <= r_mem[r_idx];
    end

    // Count, index and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_count <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SW'(i_in_word.sample);
                r_sq    <= r_sq + QW'($unsigned(sq_prod));
            end
            if (i_cmd.next) r_idx <= r_idx + 1'b1;
        end
    end

    // Deviation term and square root, two bits a step
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_nq) r_nq <= DW'(r_count) * DW'(r_sq);
        if (i_cmd.mul_ss) r_ss <= DW'(s_mag) * DW'(s_mag);
        if (i_cmd.diff) begin
            r_d   <= r_nq - r_ss;
            r_v   <= SQ_W'(r_nq - r_ss) << FRAC_SHIFT;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
            r_res <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_v >= sq_t) begin
                r_v   <= r_v - sq_t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.lim) r_lim <= root * SAT_BOUND;
    end

    // Per-sample numerator and restoring division
    always_ff @(posedge i_clk) begin
        if (i_cmd.num) begin
            r_neg <= num[NW-1];
            r_mag <= num[NW-1] ? NW'(-num) : NW'(num);
        end
        if (i_cmd.chk) begin
            r_sat  <= dividend >= SQ_W'(r_lim);
            r_rem  <= dividend;
            r_q    <= '0;
            r_dcnt <= 4'(QUO_W - 1);
        end
        if (i_cmd.div_step) begin
            if (r_rem >= dv_t) begin
                r_rem        <= r_rem - dv_t;
                r_q[r_dcnt]  <= 1'b1;
            end
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_word.passed_through <= o_status.pass;
            r_out_word.last_result    <= o_status.last_idx;
            r_out_word.value          <= o_status.pass ? r_rd_data : $signed(z_val);
        end
    end

    assign o_status.closing   = i_in_word.last_sample || (r_count == CNT_LAST);
    assign o_status.sqrt_done = r_bit[0];
    assign o_status.pass      = (r_d == '0) || (r_res == '0);
    assign o_status.div_done  = (r_dcnt == '0);
    assign o_status.last_idx  = (CW'(r_idx) == r_count - 1'b1);
    assign o_status.out_taken = r_out_valid && !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ design/z_score_normalizer.sv @@
`timescale 1ns / 1ps
// z_score_normalizer: z-score normalization of a set of Q7.8 samples.
// Input channel (i_in_valid / o_in_stall, i_in_word) takes one sample word
// per cycle while a set is loading. A word with last_sample set, or the word
// that fills the MAX_SAMPLES store, closes the set; input then stalls until
// every result of the set has been taken.
// Output channel (o_out_valid / i_out_stall, o_out_word) gives one word per
// stored sample in arrival order, Q4.11, or the raw sample with
// passed_through set when the deviation is zero; last_result marks the end.
// Sequence: after the closing word, setup (two multiplies, the
// difference, a 32-step square root at two bits per cycle, the saturation
// bound), then for each result word a store read, the numerator, the bound
// check, the 16-step restoring divider at one quotient bit per cycle and the
// output register; a passed-through result skips the check and the divider.
// Loading runs at one word per cycle. A stalled result holds in the output
// register; the divider waits for it to be taken.
// Reset (synchronous, active low) empties the set and drops any result.
module z_score_normalizer #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  zsn_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output zsn_pkg::t_out_word o_out_word
);
    import zsn_pkg::*;

    t_cmd    cmd;
    t_status status;

    zsn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    zsn_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

@@ tb/sv/z_score_normalizer_tb.sv @@
`timescale 1ns / 1ps
module z_score_normalizer_tb;
    import zsn_pkg::*;

    localparam int MAX_SAMPLES = 64;
    localparam int HOLD_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 80;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    // Normalizer prediction state
    longint              set_samples[$];
    longint              set_sum;
    longint unsigned     set_sqsum;
    t_out_word           z_expected[$];

    int  error_count = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  sets_closed = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;

    z_score_normalizer #(.MAX_SAMPLES(MAX_SAMPLES)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor of the square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Accumulate one accepted word; on a closing word queue the normalized set
    task automatic predict_word(t_in_word w);
        longint          x;
        longint unsigned ax, n, smag, dev, root, mag, q;
        longint          num;
        t_out_word       r;
        x = longint'(w.sample);
        set_samples.push_back(x);
        set_sum += x;
        ax = (x < 0) ? -x : x;
        set_sqsum += ax * ax;
        if (!(w.last_sample || set_samples.size() >= MAX_SAMPLES)) return;
        n    = set_samples.size();
        smag = (set_sum < 0) ? -set_sum : set_sum;
        dev  = n * set_sqsum - smag * smag;
        root = (dev != 0) ? int_sqrt(dev << FRAC_SHIFT) : 0;
        foreach (set_samples[k]) begin
            r = '0;
            if (root == 0) begin
                r.value          = set_samples[k][15:0];
                r.passed_through = 1'b1;
            end else begin
                num = longint'(n) * set_samples[k] - set_sum;
                mag = (num < 0) ? -num : num;
                q   = (mag << FRAC_SHIFT) / root;
                if (num < 0) r.value = (q > 32768) ? NEG_MIN : 16'(-longint'(q));
                else         r.value = (q > 32767) ? POS_MAX : 16'(q);
            end
            r.last_result = (k == n - 1);
            z_expected.push_back(r);
        end
        set_samples.delete();
        set_sum   = 0;
        set_sqsum = 0;
        sets_closed++;
    endtask

    // Send one word; called and returns at a falling edge
    task automatic send_word(logic signed [15:0] smp, logic last);
        t_in_word w;
        w.sample      = smp;
        w.last_sample = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_word  <= ($bits(t_in_word))'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample(int style, logic signed [15:0] base);
        case (style)
            0: return 16'($urandom);
            1: return 16'(int'(base) + int'($urandom_range(3)) - 1);
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'(int'($urandom_range(1023)) - 512);
        endcase
    endfunction

    // A set of len samples; last flag only on the final one unless the store fills
    task automatic send_set(int len, int style);
        logic signed [15:0] base;
        base = 16'($urandom);
        for (int k = 0; k < len; k++)
            send_word(pick_sample(style, base), (k == len - 1) && len < MAX_SAMPLES);
    endtask

    task automatic send_random_sets(int count_words);
        int sent, len;
        sent = 0;
        while (sent < count_words) begin
            len = ($urandom_range(15) == 0) ? MAX_SAMPLES : $urandom_range(1, 10);
            send_set(len, $urandom_range(4));
            sent += len;
        end
    endtask

    task automatic test_directed();
        send_word(16'sh7FFF, 1'b1);             // one-sample set passes through
        send_word(16'sh8000, 1'b0);             // extremes
        send_word(16'sh7FFF, 1'b1);
        repeat (3) send_word(16'sh1234, 1'b0);  // zero deviation
        send_word(16'sh1234, 1'b1);
        send_word(16'sh0000, 1'b0);
        send_word(16'sh0001, 1'b0);
        send_word(16'shFFFF, 1'b1);
        for (int k = 0; k < MAX_SAMPLES; k++)  // store fills without last flag
            send_word((k == 5) ? 16'sh7FFF : 16'sh8000, 1'b0);
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_random_sets(30);
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 84; recv_stall_pct = 0;
        send_random_sets(25);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0; recv_stall_pct = 84;
        send_random_sets(25);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 23; recv_stall_pct = 23;
        send_random_sets(25);
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_cycles = 400;
        send_set(6, 0);
        send_set(MAX_SAMPLES, 0);
        send_set(4, 3);
    endtask

    // Receiver stall, with a long hold when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            if (z_expected.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time, o_out_word);
                error_count++;
            end else begin
                exp_w = z_expected.pop_front();
                if (o_out_word.value !== exp_w.value ||
                    o_out_word.passed_through !== exp_w.passed_through ||
                    o_out_word.last_result !== exp_w.last_result) begin
                    $display({"%0t: mismatch expected val=%h pt=%b last=%b",
                              " actual val=%h pt=%b last=%b"},
                             $time, exp_w.value, exp_w.passed_through, exp_w.last_result,
                             o_out_word.value, o_out_word.passed_through,
                             o_out_word.last_result);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HOLD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        set_sum = 0;
        set_sqsum = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        i_in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (z_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (set_samples.size() != 0) begin
            $display("%0t: open set of %0d samples left", $time, set_samples.size());
            error_count++;
        end
        $display("Sent %0d sample words in %0d sets, checked %0d results, %0d errors",
                 words_sent, sets_closed, words_checked, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ z_score_normalizer.f @@
design/zsn_pkg.sv
design/zsn_ctrl.sv
design/zsn_datapath.sv
design/z_score_normalizer.sv
tb/sv/z_score_normalizer_tb.sv
